// ===== design/mldt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mldt_pkg
// Shared constants for the MAC device learning table: sizes, hash constants,
// frame length thresholds and result status codes.
// ----------------------------------------------------------------------------
package mldt_pkg;

    localparam int TABLE_DEPTH_DEF  = 1024;
    localparam int HASH_BUCKETS_DEF = 256;

    localparam int MAC_W   = 48;
    localparam int LEN_W   = 16;
    localparam int ETYPE_W = 16;
    localparam int WORD_W  = 32;
    localparam int VLAN_W  = 12;
    localparam int TIME_W  = 32;
    localparam int HELD_W  = 11;
    localparam int LIMIT_W = 11;
    localparam int STAT_W  = 3;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [LEN_W-1:0]   MIN_FRAME      = 16'd12;
    localparam logic [LEN_W-1:0]   MIN_ETH_HDR    = 16'd14;
    localparam logic [LEN_W-1:0]   MIN_ARP_IP     = 16'd32;
    localparam logic [LEN_W-1:0]   MIN_IPV4_SRC   = 16'd30;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    localparam logic KIND_OBSERVE = 1'b0;
    localparam logic KIND_LOOKUP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_LEARNED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_HIT      = 3'd4;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd5;

endpackage
`default_nettype wire

// ===== design/mldt_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mldt_hash
// FNV-1a over the six MAC bytes, one multiply per cycle, then the remainder
// by the bucket count through a reciprocal multiply, a difference and a fold.
// ----------------------------------------------------------------------------
module mldt_hash
    import mldt_pkg::*;
#(
    parameter int HASH_BUCKETS = HASH_BUCKETS_DEF,
    localparam int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [MAC_W-1:0] i_mac,
    output logic                  o_done,
    output logic [BW-1:0]         o_bucket
);

    // Floor of 2^32 over the bucket count. The quotient estimate made with it
    // is at most one short, so one compare and subtract ends the remainder.
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(HASH_BUCKETS));
    localparam logic [31:0] BK32  = 32'(HASH_BUCKETS);
    localparam logic [17:0] BK18  = 18'(HASH_BUCKETS);

    logic [MAC_W-1:0] r_mac;
    logic [31:0]      r_h;
    logic [31:0]      r_q;
    logic [17:0]      r_part;
    logic [BW-1:0]    r_rem;
    logic [3:0]       r_cnt;
    logic             r_mul;
    logic             r_mod;
    logic             r_done;
    logic [7:0]       w_byte;
    logic [63:0]      w_prod;
    logic [31:0]      w_quot;
    logic [31:0]      w_qk;
    logic [31:0]      w_diff;
    logic [17:0]      w_fold;

    assign w_byte = r_mac[MAC_W-1 -: 8];
    assign w_prod = 64'(r_h) * 64'(RECIP[31:0]);
    // Only a single bucket sets the top reciprocal bit; the quotient is then the hash.
    assign w_quot = RECIP[32] ? r_h : w_prod[63:32];
    assign w_qk   = r_q * BK32;
    assign w_diff = r_h - w_qk;
    assign w_fold = (r_part >= BK18) ? (r_part - BK18) : r_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_mod  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_mod && (r_cnt == 4'd2);
            if (i_start) begin
                r_mac <= i_mac;
                r_h   <= FNV_OFFSET;
                r_cnt <= '0;
                r_mul <= 1'b1;
            end else if (r_mul) begin
                r_h   <= (r_h ^ {24'd0, w_byte}) * FNV_PRIME;
                r_mac <= {r_mac[MAC_W-9:0], 8'd0};
                if (r_cnt == 4'd5) begin
                    r_cnt <= '0;
                    r_mul <= 1'b0;
                    r_mod <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 4'd1;
                end
            end else if (r_mod) begin
                case (r_cnt)
                    4'd0: begin
                        r_q   <= w_quot;
                        r_cnt <= 4'd1;
                    end
                    4'd1: begin
                        r_part <= w_diff[17:0];
                        r_cnt  <= 4'd2;
                    end
                    default: begin
                        r_rem <= w_fold[BW-1:0];
                        r_mod <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule
`default_nettype wire

// ===== design/mac_device_learning_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mac_device_learning_table
// Learns devices by source MAC in a hashed, chained table held in memory.
//
//  Channel   Signals                          Beat
//  input     i_in_valid / o_in_ready          one observe or lookup item
//  output    o_out_valid / i_out_ready        one result item
//  config    i_cfg_we / i_cfg_wdata           device limit write
//
// A result passes through the hash unit (6 hash multiplies and 3 remainder
// steps), a bucket head read, and one entry memory read and compare per
// chain entry visited. Rejected observes skip these and go straight to the
// result register. The next item can be accepted the cycle after the result
// is registered.
// Reset is synchronous; it empties all buckets, no clearing pass is needed.
// One item is worked at a time; the result register lets the next item
// start while a result waits on a stalled output.
// ----------------------------------------------------------------------------
module mac_device_learning_table
    import mldt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int HASH_BUCKETS = HASH_BUCKETS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_kind,
    input  wire logic [MAC_W-1:0]   i_src_mac,
    input  wire logic [LEN_W-1:0]   i_frame_length,
    input  wire logic               i_is_arp,
    input  wire logic [ETYPE_W-1:0] i_ether_type,
    input  wire logic [WORD_W-1:0]  i_word_at_26,
    input  wire logic [WORD_W-1:0]  i_word_at_28,
    input  wire logic [VLAN_W-1:0]  i_vlan_tag,
    input  wire logic [TIME_W-1:0]  i_now_seconds,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [STAT_W-1:0]       o_status,
    output logic [WORD_W-1:0]       o_entry_ip,
    output logic [VLAN_W-1:0]       o_entry_vlan,
    output logic [TIME_W-1:0]       o_entry_first_seen,
    output logic [TIME_W-1:0]       o_entry_last_seen,
    output logic [HELD_W-1:0]       o_devices_held
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [IW-1:0]     nxt;
        logic              nxt_used;
        logic [WORD_W-1:0] ip;
        logic [VLAN_W-1:0] vlan;
        logic [TIME_W-1:0] first;
        logic [TIME_W-1:0] last;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_HEAD, S_WALK, S_CMP, S_RES
    } t_state;

    t_state r_state;

    logic [LIMIT_W-1:0] r_limit;
    logic [CW-1:0]      r_count;

    logic               r_kind;
    logic [MAC_W-1:0]   r_mac;
    logic [LEN_W-1:0]   r_len;
    logic               r_arp;
    logic [ETYPE_W-1:0] r_etype;
    logic [WORD_W-1:0]  r_w26;
    logic [WORD_W-1:0]  r_w28;
    logic [VLAN_W-1:0]  r_vlan;
    logic [TIME_W-1:0]  r_now;

    logic [BW-1:0]      r_bkt;
    logic [IW-1:0]      r_cur;
    logic               r_cv;
    logic [CW-1:0]      r_steps;

    logic [IW-1:0]           r_head_mem [HASH_BUCKETS];
    logic [HASH_BUCKETS-1:0] r_bused;
    logic [IW-1:0]           r_head_rd;
    logic                    r_hv_rd;
    t_entry                  r_ent_mem [TABLE_DEPTH];
    t_entry                  r_ent_rd;

    logic [STAT_W-1:0] r_res_status;
    t_entry            r_res;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [WORD_W-1:0] r_out_ip;
    logic [VLAN_W-1:0] r_out_vlan;
    logic [TIME_W-1:0] r_out_first;
    logic [TIME_W-1:0] r_out_last;
    logic [HELD_W-1:0] r_out_held;

    logic          w_accept;
    logic          w_reject;
    logic          w_hash_done;
    logic [BW-1:0] w_bucket;
    logic          w_walk_go;
    logic          w_match;
    logic          w_full;
    logic [LW-1:0] w_eff_limit;
    logic [WORD_W-1:0] w_cand;
    t_entry        w_base;
    t_entry        w_upd;
    logic          w_ent_we;
    logic [IW-1:0] w_ent_waddr;
    logic          w_head_we;
    logic          w_res_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_reject   = (i_kind == KIND_OBSERVE) &&
                        ((i_frame_length < MIN_FRAME) || (i_src_mac == '0));
    assign w_res_load = (r_state == S_RES) && (!r_out_valid || i_out_ready);

    mldt_hash #(
        .HASH_BUCKETS(HASH_BUCKETS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && !w_reject),
        .i_mac   (i_src_mac),
        .o_done  (w_hash_done),
        .o_bucket(w_bucket)
    );

    // The chain walk is bounded by the number of entries held.
    assign w_walk_go = (r_state == S_WALK) && r_cv && (r_steps < r_count) &&
                       ({1'b0, r_cur} < (IW + 1)'(TABLE_DEPTH));
    assign w_match   = (r_ent_rd.mac == r_mac);

    // A limit of zero or beyond the table size means the whole table.
    always_comb begin
        if ((r_limit == '0) || (LW'(r_limit) > LW'(TABLE_DEPTH))) begin
            w_eff_limit = LW'(TABLE_DEPTH);
        end else begin
            w_eff_limit = LW'(r_limit);
        end
    end
    assign w_full = (LW'(r_count) >= w_eff_limit);

    // Candidate source address taken from the frame.
    always_comb begin
        w_cand = '0;
        if (r_len >= MIN_ETH_HDR) begin
            if (r_arp) begin
                if (r_len >= MIN_ARP_IP) begin
                    w_cand = r_w28;
                end
            end else if ((r_etype == ETHERTYPE_IPV4) && (r_len >= MIN_IPV4_SRC)) begin
                w_cand = r_w26;
            end
        end
    end

    // A hit updates the stored entry; a new entry starts from zeroed fields.
    always_comb begin
        if (r_state == S_CMP) begin
            w_base = r_ent_rd;
        end else begin
            w_base          = '0;
            w_base.mac      = r_mac;
            w_base.nxt      = r_head_rd;
            w_base.nxt_used = r_hv_rd;
        end
        w_upd       = w_base;
        w_upd.first = (w_base.first == '0) ? r_now : w_base.first;
        w_upd.last  = r_now;
        if (r_vlan != '0) begin
            w_upd.vlan = r_vlan;
        end
        if ((w_cand != '0) && (w_base.ip == '0)) begin
            w_upd.ip = w_cand;
        end
    end

    assign w_head_we   = (r_state == S_WALK) && !w_walk_go &&
                         (r_kind == KIND_OBSERVE) && !w_full;
    assign w_ent_we    = w_head_we ||
                         ((r_state == S_CMP) && w_match && (r_kind == KIND_OBSERVE));
    assign w_ent_waddr = (r_state == S_CMP) ? r_cur : r_count[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_hash_done) begin
            r_head_rd <= r_head_mem[w_bucket];
        end
        if (w_head_we) begin
            r_head_mem[r_bkt] <= r_count[IW-1:0];
        end
        if (w_walk_go) begin
            r_ent_rd <= r_ent_mem[r_cur];
        end
        if (w_ent_we) begin
            r_ent_mem[w_ent_waddr] <= w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_bused     <= '0;
            r_hv_rd     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_hash_done) begin
                r_hv_rd <= r_bused[w_bucket];
                r_bkt   <= w_bucket;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind  <= i_kind;
                        r_mac   <= i_src_mac;
                        r_len   <= i_frame_length;
                        r_arp   <= i_is_arp;
                        r_etype <= i_ether_type;
                        r_w26   <= i_word_at_26;
                        r_w28   <= i_word_at_28;
                        r_vlan  <= i_vlan_tag;
                        r_now   <= i_now_seconds;
                        if (w_reject) begin
                            r_res_status <= ST_REJECTED;
                            r_res        <= '0;
                            r_state      <= S_RES;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_cur   <= r_head_rd;
                    r_cv    <= r_hv_rd;
                    r_steps <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (w_walk_go) begin
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_RES;
                        if (r_kind == KIND_LOOKUP) begin
                            r_res_status <= ST_MISS;
                            r_res        <= '0;
                        end else if (w_full) begin
                            r_res_status <= ST_FULL;
                            r_res        <= '0;
                        end else begin
                            r_res_status   <= ST_LEARNED;
                            r_res          <= w_upd;
                            r_bused[r_bkt] <= 1'b1;
                            r_count        <= r_count + CW'(1);
                        end
                    end
                end
                S_CMP: begin
                    if (w_match) begin
                        r_state <= S_RES;
                        if (r_kind == KIND_LOOKUP) begin
                            r_res_status <= ST_HIT;
                            r_res        <= r_ent_rd;
                        end else begin
                            r_res_status <= ST_UPDATED;
                            r_res        <= w_upd;
                        end
                    end else begin
                        r_cur   <= r_ent_rd.nxt;
                        r_cv    <= r_ent_rd.nxt_used;
                        r_steps <= r_steps + CW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_RES: begin
                    if (w_res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_status <= r_res_status;
            r_out_ip     <= r_res.ip;
            r_out_vlan   <= r_res.vlan;
            r_out_first  <= r_res.first;
            r_out_last   <= r_res.last;
            r_out_held   <= HELD_W'(r_count);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_entry_ip         = r_out_ip;
    assign o_entry_vlan       = r_out_vlan;
    assign o_entry_first_seen = r_out_first;
    assign o_entry_last_seen  = r_out_last;
    assign o_devices_held     = r_out_held;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("device count beyond table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + CW'(1)))
        else $error("device count moved by more than one");

    a_learn_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_res_status == ST_LEARNED))
        else $error("count grew without a learned entry");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input taken while an item is in flight");

endmodule
`default_nettype wire
